@@ design/shaped_slew_limiter_unit_macros.svh @@
// ----------------------------------------------------------------------------
// shaped_slew_limiter_unit macros
// assertion helpers used by the slew limiter sequencer
// ----------------------------------------------------------------------------
`ifndef SHAPED_SLEW_LIMITER_UNIT_MACROS_SVH
`define SHAPED_SLEW_LIMITER_UNIT_MACROS_SVH

// same-cycle implication
`define SSL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slew limiter same-cycle check failed");

// next-cycle implication
`define SSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slew limiter next-cycle check failed");

`endif

@@ design/ssl_pkg.sv @@
// ----------------------------------------------------------------------------
// ssl_pkg
// types, fixed-point constants and the exp2 root table of the slew limiter
// ----------------------------------------------------------------------------
package ssl_pkg;

  // fixed datapath widths
  localparam int MUL_W      = 32;
  localparam int PROD_W     = 64;
  localparam int QUO_W      = 27;
  localparam int E_W        = 29;
  localparam int EBIAS_W    = 18;
  localparam int P16_W      = 23;
  localparam int INT_W      = 7;
  localparam int SH_W       = 8;
  localparam int BASE_W     = 49;
  localparam int Y_W        = 30;
  localparam int QUO5_W     = 28;
  localparam int CF_W       = 28;
  localparam int STEP_W     = 45;
  localparam int SHAPE_W    = 17;
  localparam int KNOB_W     = 17;
  localparam int PERIOD_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ROOT_MAX   = 12;

  // floor(2^37 / 40) == floor(2^34 / 5)
  localparam logic [MUL_W-1:0]        R_RECIP    = 32'd3435973836;
  // log2(1e5) in Q.16
  localparam logic [MUL_W-1:0]        K_SLOPE    = 32'd1088529;
  // log2(1e4) + log2(1e5) in Q.16, folds the exponent bias
  localparam logic signed [P16_W-1:0] P_OFFS     = 23'sd1959353;
  localparam logic signed [E_W-1:0]   E_MIN      = -29'sd65536;
  localparam logic signed [E_W-1:0]   E_MAX      = 29'sd131072;
  localparam logic signed [E_W-1:0]   E_BIAS     = 29'sd65536;
  localparam logic [EBIAS_W-1:0]      EBIAS_MAX  = 18'd196608;
  localparam logic [MUL_W-1:0]        ONE_Q30    = 32'h4000_0000;
  localparam logic [PROD_W-1:0]       HALF_Q30   = 64'h2000_0000;
  localparam logic [BASE_W-1:0]       STEP_CAP   = 49'h1_0000_0000_0000;
  localparam logic [SHAPE_W-1:0]      ONE_Q16    = 17'h1_0000;
  localparam logic [PERIOD_W-1:0]     PERIOD_RST = 32'd89478;
  localparam logic signed [SH_W-1:0]  SHIFT_BASE = 8'sd28;
  localparam logic [31:0]             DIV40      = 32'd40;
  localparam logic [Y_W-1:0]          DIV5       = 30'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHAPE     = 3'd0,
    CFG_RISE_KNOB = 3'd1,
    CFG_FALL_KNOB = 3'd2,
    CFG_PERIOD    = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [SHAPE_W-1:0]  shape;
    logic [KNOB_W-1:0]   rise_knob;
    logic [KNOB_W-1:0]   fall_knob;
    logic [PERIOD_W-1:0] period;
  } cfg_t;

  typedef struct packed {
    logic [PROD_W-1:0] c;
    logic [MUL_W-1:0]  a;
    logic [MUL_W-1:0]  b;
  } mac_req_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] b;
    r = '0;
    v = x;
    for (int i = 0; i < 32; i++) begin
      b = 64'd1 << (62 - 2 * i);
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // successive roots 2^(2^-m) in Q2.30, entry m-1 holds root m
  function automatic logic [ROOT_MAX*32-1:0] root_table();
    logic [ROOT_MAX*32-1:0] t;
    logic [63:0]            root;
    t    = '0;
    root = isqrt64(64'd1 << 61);
    for (int m = 0; m < ROOT_MAX; m++) begin
      t[m*32 +: 32] = root[31:0];
      root          = isqrt64(root << 30);
    end
    return t;
  endfunction

endpackage

@@ design/ssl_mac.sv @@
// ----------------------------------------------------------------------------
// ssl_mac
// shared 32x32 multiply with 64 bit addend
// ----------------------------------------------------------------------------
module ssl_mac (
  input  ssl_pkg::mac_req_t              req_i,
  output logic [ssl_pkg::PROD_W-1:0]     prod_o
);

  logic [ssl_pkg::PROD_W-1:0] mul;

  assign mul    = ssl_pkg::PROD_W'(req_i.a) * ssl_pkg::PROD_W'(req_i.b);
  assign prod_o = mul + req_i.c;

endmodule

@@ design/ssl_cfg.sv @@
// ----------------------------------------------------------------------------
// ssl_cfg
// configuration registers, shape amount clamped to one
// ----------------------------------------------------------------------------
module ssl_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ssl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ssl_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output ssl_pkg::cfg_t                     cfg_o
);

  logic [ssl_pkg::SHAPE_W-1:0]  shape_q, shape_d;
  logic [ssl_pkg::KNOB_W-1:0]   rise_q, rise_d;
  logic [ssl_pkg::KNOB_W-1:0]   fall_q, fall_d;
  logic [ssl_pkg::PERIOD_W-1:0] period_q, period_d;

  always_comb begin
    shape_d  = shape_q;
    rise_d   = rise_q;
    fall_d   = fall_q;
    period_d = period_q;
    if (cfg_we_i) begin
      unique case (ssl_pkg::cfg_idx_e'(cfg_idx_i))
        ssl_pkg::CFG_SHAPE:     shape_d  = cfg_wdata_i[ssl_pkg::SHAPE_W-1:0];
        ssl_pkg::CFG_RISE_KNOB: rise_d   = cfg_wdata_i[ssl_pkg::KNOB_W-1:0];
        ssl_pkg::CFG_FALL_KNOB: fall_d   = cfg_wdata_i[ssl_pkg::KNOB_W-1:0];
        ssl_pkg::CFG_PERIOD:    period_d = cfg_wdata_i[ssl_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= '0;
      rise_q   <= '0;
      fall_q   <= '0;
      period_q <= ssl_pkg::PERIOD_RST;
    end else begin
      shape_q  <= shape_d;
      rise_q   <= rise_d;
      fall_q   <= fall_d;
      period_q <= period_d;
    end
  end

  // shape above one acts as one
  assign cfg_o.shape     = (shape_q > ssl_pkg::ONE_Q16) ? ssl_pkg::ONE_Q16 : shape_q;
  assign cfg_o.rise_knob = rise_q;
  assign cfg_o.fall_knob = fall_q;
  assign cfg_o.period    = period_q;

endmodule

@@ design/ssl_seq.sv @@
// ----------------------------------------------------------------------------
// ssl_seq
// sequencer and datapath registers, drives the shared multiply-add unit
// ----------------------------------------------------------------------------
`include "shaped_slew_limiter_unit_macros.svh"

module ssl_seq #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    rise_cv_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    fall_cv_i,
  input  ssl_pkg::cfg_t                     cfg_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]    out_sample_o,
  output ssl_pkg::mac_req_t                 mac_req_o,
  input  logic [ssl_pkg::PROD_W-1:0]        mac_prod_i
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int TB = EXP_TABLE_BITS;
  localparam int MW = $clog2(EXP_TABLE_BITS);
  localparam logic [ssl_pkg::ROOT_MAX*32-1:0] ROOTS = ssl_pkg::root_table();

  typedef enum logic [3:0] {
    S_IDLE, S_CVDIV, S_CORR, S_EXPON, S_LOG, S_MANT, S_BASE,
    S_SHIFT, S_SHGAP, S_DIV5, S_CF, S_STEPLO, S_STEPHI
  } state_e;

  state_e                           state_q, state_d;
  logic                             out_valid_q, out_valid_d;
  logic signed [SW-1:0]             out_q, out_d;
  logic signed [SW-1:0]             held_q, held_d;

  logic signed [SW-1:0]             target_q, target_d;
  logic [SW-1:0]                    gap_q, gap_d;
  logic [SW-1:0]                    cvmag_q, cvmag_d;
  logic                             cvneg_q, cvneg_d;
  logic                             dir_q, dir_d;
  logic [ssl_pkg::QUO_W-1:0]        quo_q, quo_d;
  logic [ssl_pkg::EBIAS_W-1:0]      ebias_q, ebias_d;
  logic signed [ssl_pkg::INT_W-1:0] int_q, int_d;
  logic [TB-1:0]                    kbits_q, kbits_d;
  logic [MW-1:0]                    m_q, m_d;
  logic [ssl_pkg::MUL_W-1:0]        acc_q, acc_d;
  logic [ssl_pkg::PROD_W-1:0]       prod_q, prod_d;
  logic [ssl_pkg::BASE_W-1:0]       base_q, base_d;
  logic [ssl_pkg::Y_W-1:0]          y_q, y_d;
  logic [ssl_pkg::QUO5_W-1:0]       quo5_q, quo5_d;
  logic [ssl_pkg::CF_W-1:0]         cf_q, cf_d;
  logic [ssl_pkg::CF_W-1:0]         lohi_q, lohi_d;

  // combinational helpers
  logic signed [SW:0]               diff;
  logic signed [SW:0]               diff_neg;
  logic signed [SW-1:0]             cv_sel;
  logic signed [SW-1:0]             cv_neg;
  logic                             in_dir;
  logic [31:0]                      rem40;
  logic signed [ssl_pkg::E_W-1:0]   q_s;
  logic signed [ssl_pkg::E_W-1:0]   knob_s;
  logic signed [ssl_pkg::E_W-1:0]   e_sum;
  logic signed [ssl_pkg::P16_W-1:0] p16;
  logic signed [ssl_pkg::SH_W-1:0]  sh;
  logic [ssl_pkg::PROD_W-1:0]       shifted;
  logic [ssl_pkg::Y_W-1:0]          rem5;
  logic [ssl_pkg::STEP_W-1:0]       step;
  logic                             reach;
  logic [SW-1:0]                    moved;
  logic signed [SW-1:0]             new_h;
  logic                             in_fire;
  logic                             done_fire;

  assign in_ready_o   = (state_q == S_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;

  // request capture
  assign diff     = {in_sample_i[SW-1], in_sample_i} - {held_q[SW-1], held_q};
  assign diff_neg = -diff;
  assign in_dir   = !diff[SW] && (diff != '0);
  assign cv_sel   = in_dir ? rise_cv_i : fall_cv_i;
  assign cv_neg   = -cv_sel;

  // divide-by-forty correction and exponent sum
  assign rem40  = 32'(cvmag_q) - (32'({quo_q, 5'b0}) + 32'({quo_q, 3'b0}));
  assign q_s    = signed'({2'b0, quo_q});
  assign knob_s = signed'(ssl_pkg::E_W'(dir_q ? cfg_i.rise_knob : cfg_i.fall_knob));
  assign e_sum  = (cvneg_q ? -q_s : q_s) + knob_s;

  // log-domain exponent from the slope product
  assign p16 = ssl_pkg::P_OFFS - signed'({1'b0, mac_prod_i[37:16]});

  // base step shift
  assign sh      = ssl_pkg::SHIFT_BASE - signed'({int_q[ssl_pkg::INT_W-1], int_q});
  assign shifted = prod_q >> sh[5:0];

  // divide-by-five correction
  assign rem5 = y_q - (ssl_pkg::Y_W'({quo5_q, 2'b0}) + ssl_pkg::Y_W'(quo5_q));

  // final step and move
  assign step  = mac_prod_i[ssl_pkg::STEP_W-1:0];
  assign reach = (step >= ssl_pkg::STEP_W'(gap_q));
  assign moved = dir_q ? (SW'(held_q) + step[SW-1:0]) : (SW'(held_q) - step[SW-1:0]);
  assign new_h = reach ? target_q : signed'(moved);

  assign done_fire = (state_q == S_STEPHI) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    held_d      = held_q;
    target_d    = target_q;
    gap_d       = gap_q;
    cvmag_d     = cvmag_q;
    cvneg_d     = cvneg_q;
    dir_d       = dir_q;
    quo_d       = quo_q;
    ebias_d     = ebias_q;
    int_d       = int_q;
    kbits_d     = kbits_q;
    m_d         = m_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    base_d      = base_q;
    y_d         = y_q;
    quo5_d      = quo5_q;
    cf_d        = cf_q;
    lohi_d      = lohi_q;
    mac_req_o   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          target_d = in_sample_i;
          dir_d    = in_dir;
          gap_d    = diff[SW] ? diff_neg[SW-1:0] : diff[SW-1:0];
          cvneg_d  = cv_sel[SW-1];
          cvmag_d  = cv_sel[SW-1] ? cv_neg : cv_sel;
          state_d  = S_CVDIV;
        end
      end
      S_CVDIV: begin
        mac_req_o.a = ssl_pkg::MUL_W'(cvmag_q);
        mac_req_o.b = ssl_pkg::R_RECIP;
        quo_d       = mac_prod_i[63:37];
        state_d     = S_CORR;
      end
      S_CORR: begin
        if (rem40 >= ssl_pkg::DIV40) begin
          quo_d = quo_q + 1'b1;
        end
        state_d = S_EXPON;
      end
      S_EXPON: begin
        if (e_sum < ssl_pkg::E_MIN) begin
          ebias_d = '0;
        end else if (e_sum > ssl_pkg::E_MAX) begin
          ebias_d = ssl_pkg::EBIAS_MAX;
        end else begin
          ebias_d = ssl_pkg::EBIAS_W'(e_sum + ssl_pkg::E_BIAS);
        end
        state_d = S_LOG;
      end
      S_LOG: begin
        mac_req_o.a = ssl_pkg::MUL_W'(ebias_q);
        mac_req_o.b = ssl_pkg::K_SLOPE;
        int_d       = p16[ssl_pkg::P16_W-1:16];
        kbits_d     = p16[15 -: TB];
        acc_d       = ssl_pkg::ONE_Q30;
        m_d         = '0;
        state_d     = S_MANT;
      end
      S_MANT: begin
        // one fraction bit per cycle, multiply by its root when set
        mac_req_o.a = acc_q;
        mac_req_o.b = ROOTS[{m_q, 5'b0} +: 32];
        mac_req_o.c = ssl_pkg::HALF_Q30;
        if (kbits_q[TB-1]) begin
          acc_d = mac_prod_i[61:30];
        end
        kbits_d = kbits_q << 1;
        m_d     = m_q + 1'b1;
        if (m_q == MW'(TB - 1)) begin
          state_d = S_BASE;
        end
      end
      S_BASE: begin
        mac_req_o.a = acc_q;
        mac_req_o.b = cfg_i.period;
        prod_d      = mac_prod_i;
        state_d     = S_SHIFT;
      end
      S_SHIFT: begin
        if (sh <= 0) begin
          base_d = ssl_pkg::STEP_CAP;
        end else if (shifted > ssl_pkg::PROD_W'(ssl_pkg::STEP_CAP)) begin
          base_d = ssl_pkg::STEP_CAP;
        end else begin
          base_d = shifted[ssl_pkg::BASE_W-1:0];
        end
        state_d = S_SHGAP;
      end
      S_SHGAP: begin
        mac_req_o.a = ssl_pkg::MUL_W'(gap_q);
        mac_req_o.b = ssl_pkg::MUL_W'(cfg_i.shape);
        y_d         = mac_prod_i[48:19];
        state_d     = S_DIV5;
      end
      S_DIV5: begin
        mac_req_o.a = ssl_pkg::MUL_W'(y_q);
        mac_req_o.b = ssl_pkg::R_RECIP;
        quo5_d      = mac_prod_i[61:34];
        state_d     = S_CF;
      end
      S_CF: begin
        cf_d = ssl_pkg::CF_W'(ssl_pkg::ONE_Q16 - cfg_i.shape)
             + quo5_q + ssl_pkg::CF_W'(rem5 >= ssl_pkg::DIV5);
        state_d = S_STEPLO;
      end
      S_STEPLO: begin
        mac_req_o.a = base_q[31:0];
        mac_req_o.b = ssl_pkg::MUL_W'(cf_q);
        lohi_d      = mac_prod_i[59:32];
        state_d     = S_STEPHI;
      end
      S_STEPHI: begin
        mac_req_o.a = ssl_pkg::MUL_W'(base_q[ssl_pkg::BASE_W-1:32]);
        mac_req_o.b = ssl_pkg::MUL_W'(cf_q);
        mac_req_o.c = ssl_pkg::PROD_W'(lohi_q);
        if (done_fire) begin
          held_d      = new_h;
          out_d       = new_h;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      held_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      held_q      <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    gap_q    <= gap_d;
    cvmag_q  <= cvmag_d;
    cvneg_q  <= cvneg_d;
    dir_q    <= dir_d;
    quo_q    <= quo_d;
    ebias_q  <= ebias_d;
    int_q    <= int_d;
    kbits_q  <= kbits_d;
    m_q      <= m_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    base_q   <= base_d;
    y_q      <= y_d;
    quo5_q   <= quo5_d;
    cf_q     <= cf_d;
    lohi_q   <= lohi_d;
  end

  `SSL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_fire, state_q != S_IDLE)
  `SSL_ASSERT_NEXT(a_result_posted, clk_i, rst_ni, done_fire, out_valid_q && (out_q == held_q))
  `SSL_ASSERT_NOW(a_rise_bounded, clk_i, rst_ni, done_fire && dir_q, (new_h <= target_q) && (new_h >= held_q))
  `SSL_ASSERT_NOW(a_fall_bounded, clk_i, rst_ni, done_fire && !dir_q, (new_h >= target_q) && (new_h <= held_q))
  `SSL_ASSERT_NOW(a_base_capped, clk_i, rst_ni, state_q == S_STEPLO, base_q <= ssl_pkg::STEP_CAP)

endmodule

@@ design/shaped_slew_limiter_unit.sv @@
// ----------------------------------------------------------------------------
// shaped_slew_limiter_unit: exponential-rate slew limiter on one shared multiply-add unit
// requests: one in flight at a time, the next is accepted once the sequencer is back in idle
// reset: async active low, held output to zero, sample_period to 89478, shape and knobs to zero
// ----------------------------------------------------------------------------
module shaped_slew_limiter_unit #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [ssl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ssl_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // input request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    rise_cv_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    fall_cv_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]    out_sample_o
);

  // the sequencer walks each request through these steps, multiplies on the shared multiply-add unit:
  //   cv / 40 by reciprocal multiply, then a remainder correction
  //   exponent = cv/40 + knob, clamped to -1..2 (Q.16), kept with a +1 bias
  //   log2 of the rate: p = log2(1e4) - e * log2(1e5), split into integer and fraction
  //   mantissa: one fraction bit per cycle, multiply by the matching 2^(2^-m) root
  //   base step = mantissa * period, shifted by the integer part, capped at 2^48
  //   crossfade = (1 - shape) + shape * gap / 40, divide by five by reciprocal
  //   step = base * crossfade >> 32 as two partial products, the second adds the first
  // the step never carries past the target; an equal target leaves the output as is

  ssl_pkg::cfg_t                cfg;
  ssl_pkg::mac_req_t            mac_req;
  logic [ssl_pkg::PROD_W-1:0]   mac_prod;

  // register file; write it only while idle, the block itself does not enforce this
  ssl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // the single 32x32 multiplier with 64 bit addend
  ssl_mac u_mac (
    .req_i  (mac_req),
    .prod_o (mac_prod)
  );

  // sequencer; the output register lets a new request in while a result waits,
  // the last step stalls only if the previous result is still not taken
  ssl_seq #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_sample_i  (in_sample_i),
    .rise_cv_i    (rise_cv_i),
    .fall_cv_i    (fall_cv_i),
    .cfg_i        (cfg),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_sample_o (out_sample_o),
    .mac_req_o    (mac_req),
    .mac_prod_i   (mac_prod)
  );

endmodule
